// File: hw/rtl/mcdfs_pkg.sv
// shared types and constants for the depth-first maze carver
package mcdfs_pkg;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int GRID_W     = 7;
  localparam int START_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 2'd3;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  // result field widths
  localparam int EVENT_W = 3;
  localparam int COORD_W = 6;
  localparam int DEPTH_W = 13;

  // operations
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_STEP    = 1'b1;

  // result events
  localparam logic [EVENT_W-1:0] EV_CARVED  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_BACK    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DONE    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_RESTART = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ERROR   = 3'd4;

  // directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // cell map entry: visited flag over four wall bits
  localparam int         CELL_W    = 5;
  localparam int         VIS_BIT   = 4;
  localparam logic [3:0] WALLS_ALL = 4'hF;

  typedef logic [3:0][1:0] dir_order_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] draw_first;
    logic [1:0] draw_second;
    logic       draw_third;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [1:0]         direction;
    logic [DEPTH_W-1:0] depth;
  } out_item_t;

endpackage

// File: hw/rtl/maze_carver_dfs_backtracker.sv
// top level of the depth-first backtracking maze carver
// A grid maze carver with an explicit cell stack. A restart transaction sweeps the
// cell map (visited flag plus four walls per cell) one entry per cycle over all
// 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, 4096 at the default 64 x 64;
// the same sweep runs once after reset, and the input stays not ready until it ends
// (config writes are taken throughout). A step transaction reads the stack top, then
// tries the directions in the order set by its three draws through one shared
// neighbor unit and the single read port of the cell map: it accepts and reads the
// stack top, tests each direction against the grid, reads the visited flag of a
// neighbor that stays on it, rewrites both cells' walls when a passage is carved,
// and hands off the result (a carve after three visited neighbors is the longest
// step, and a step on an empty stack goes straight to the hand-off). A stalled
// output adds its stall cycles to the hand-off. One transaction is worked on at a
// time; the next is accepted as soon as the result sits in the output register.
module maze_carver_dfs_backtracker
  import mcdfs_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // geometry
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int AW        = XW + YW;
  localparam int MAP_DEPTH = 1 << AW;
  localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int SAW       = $clog2(CELLS);
  localparam int CNTW      = $clog2(CELLS + 1);
  localparam int XCW       = (XW + 1 > GRID_W) ? XW + 1 : GRID_W;
  localparam int YCW       = (YW + 1 > GRID_W) ? YW + 1 : GRID_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_SEED   = 9'b000000100,
    S_TOP    = 9'b000001000,
    S_PROBE  = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_CUR    = 9'b001000000,
    S_NWR    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  // fisher-yates shuffle of up, right, down, left from the three draws
  function automatic dir_order_t dir_order(input in_item_t it);
    dir_order_t o;
    logic [1:0] j2;
    logic [1:0] t;
    o[0] = DIR_UP;
    o[1] = DIR_RIGHT;
    o[2] = DIR_DOWN;
    o[3] = DIR_LEFT;
    t = o[3];
    o[3] = o[it.draw_first];
    o[it.draw_first] = t;
    j2 = (it.draw_second == 2'd3) ? 2'd0 : it.draw_second;
    t = o[2];
    o[2] = o[j2];
    o[j2] = t;
    t = o[1];
    o[1] = o[it.draw_third];
    o[it.draw_third] = t;
    return o;
  endfunction

  // config registers
  logic [GRID_W-1:0]  grid_width;
  logic [GRID_W-1:0]  grid_height;
  logic [START_W-1:0] start_x;
  logic [START_W-1:0] start_y;

  // control and working registers
  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic            clr_seed;
  logic [CNTW-1:0] count;
  dir_order_t      order;
  logic [1:0]      idx;
  logic [XW-1:0]   cur_x;
  logic [YW-1:0]   cur_y;
  logic [XW-1:0]   nx_r;
  logic [YW-1:0]   ny_r;
  logic [3:0]      nbr_walls;
  out_item_t       res;

  // datapath wires
  logic            cfg_bad;
  logic [XCW-1:0]  used_w;
  logic [YCW-1:0]  used_h;
  logic [1:0]      cur_dir;
  logic [1:0]      opp_dir;
  logic            nbr_ok;
  logic [XW-1:0]   nbr_x;
  logic [YW-1:0]   nbr_y;
  logic [CNTW-1:0] cnt_dec;
  logic [CNTW-1:0] cnt_inc;
  logic            stack_full;

  logic              cell_we;
  logic [AW-1:0]     cell_waddr;
  logic [CELL_W-1:0] cell_wdata;
  logic [AW-1:0]     cell_raddr;
  logic [CELL_W-1:0] cell_rdata;
  logic              stack_we;
  logic [SAW-1:0]    stack_waddr;
  logic [AW-1:0]     stack_wdata;
  logic [AW-1:0]     stack_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // restart is refused for an empty or oversized grid or a start off the grid
  assign cfg_bad = (grid_width == '0) || (grid_height == '0)
                || (XCW'(grid_width) > XCW'(MAX_WIDTH))
                || (YCW'(grid_height) > YCW'(MAX_HEIGHT))
                || (GRID_W'(start_x) >= grid_width)
                || (GRID_W'(start_y) >= grid_height);

  // live grid size, clipped to the map
  assign used_w = (XCW'(grid_width) > XCW'(MAX_WIDTH)) ? XCW'(MAX_WIDTH)
                                                      : XCW'(grid_width);
  assign used_h = (YCW'(grid_height) > YCW'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT)
                                                        : YCW'(grid_height);

  assign cur_dir    = order[idx];
  assign opp_dir    = {~cur_dir[1], cur_dir[0]};
  assign cnt_dec    = count - 1'b1;
  assign cnt_inc    = count + 1'b1;
  assign stack_full = (count >= CNTW'(CELLS));

  // shared neighbor unit, stepped through the direction order
  mcdfs_nbr #(
    .XW  (XW),
    .YW  (YW),
    .XCW (XCW),
    .YCW (YCW)
  ) u_nbr (
    .cur_x  (cur_x),
    .cur_y  (cur_y),
    .dir    (cur_dir),
    .used_w (used_w),
    .used_h (used_h),
    .ok     (nbr_ok),
    .nbr_x  (nbr_x),
    .nbr_y  (nbr_y)
  );

  // memory port control
  always_comb begin
    cell_we     = 1'b0;
    cell_waddr  = {cur_y, cur_x};
    cell_wdata  = {1'b1, WALLS_ALL};
    cell_raddr  = {nbr_y, nbr_x};
    stack_we    = 1'b0;
    stack_waddr = count[SAW-1:0];
    stack_wdata = {ny_r, nx_r};
    unique case (state)
      S_CLEAR: begin
        // every entry back to unvisited with all walls up
        cell_we    = 1'b1;
        cell_waddr = clr_addr;
        cell_wdata = {1'b0, WALLS_ALL};
      end
      S_SEED: begin
        if (!cfg_bad) begin
          cell_we     = 1'b1;
          cell_waddr  = {YW'(start_y), XW'(start_x)};
          cell_wdata  = {1'b1, WALLS_ALL};
          stack_we    = 1'b1;
          stack_waddr = '0;
          stack_wdata = {YW'(start_y), XW'(start_x)};
        end
      end
      S_CHECK: begin
        // fetch the current cell walls for the carve
        cell_raddr = {cur_y, cur_x};
      end
      S_CUR: begin
        cell_we    = 1'b1;
        cell_waddr = {cur_y, cur_x};
        cell_wdata = {1'b1, cell_rdata[3:0] & ~(4'b0001 << cur_dir)};
      end
      S_NWR: begin
        cell_we    = 1'b1;
        cell_waddr = {ny_r, nx_r};
        cell_wdata = {1'b1, nbr_walls & ~(4'b0001 << opp_dir)};
        stack_we   = 1'b1;
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  // visited flag and walls per cell
  mcdfs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAP_DEPTH)
  ) u_cell_map (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // cell stack, always read at the top
  mcdfs_ram #(
    .WIDTH (AW),
    .DEPTH (CELLS)
  ) u_cell_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (cnt_dec[SAW-1:0]),
    .rdata (stack_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_seed    <= 1'b0;
      count       <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
      start_x     <= '0;
      start_y     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          CFG_START_X:     start_x     <= cfg_data[START_W-1:0];
          CFG_START_Y:     start_y     <= cfg_data[START_W-1:0];
          default:         grid_width  <= grid_width;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            order <= dir_order(in_data);
            idx   <= '0;
            if (in_data.operation == OP_RESTART) begin
              count    <= '0;
              clr_addr <= '0;
              clr_seed <= 1'b1;
              state    <= S_CLEAR;
            end else if (count == '0) begin
              // empty stack: maze is finished
              res   <= '{EV_DONE, '0, '0, DIR_UP, '0};
              state <= S_FINISH;
            end else begin
              // stack top read issued this cycle
              state <= S_TOP;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= clr_seed ? S_SEED : S_IDLE;
          end
        end
        S_SEED: begin
          clr_seed <= 1'b0;
          if (cfg_bad) begin
            res <= '{EV_ERROR, '0, '0, DIR_UP, '0};
          end else begin
            count <= CNTW'(1);
            res   <= '{EV_RESTART, COORD_W'(start_x), COORD_W'(start_y), DIR_UP,
                       DEPTH_W'(1)};
          end
          state <= S_FINISH;
        end
        S_TOP: begin
          {cur_y, cur_x} <= stack_rdata;
          state          <= S_PROBE;
        end
        S_PROBE: begin
          if (nbr_ok) begin
            // neighbor visited flag read issued this cycle
            nx_r  <= nbr_x;
            ny_r  <= nbr_y;
            state <= S_CHECK;
          end else if (idx == 2'd3) begin
            count <= cnt_dec;
            res   <= '{EV_BACK, COORD_W'(cur_x), COORD_W'(cur_y), DIR_UP,
                       DEPTH_W'(cnt_dec)};
            state <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CHECK: begin
          if (cell_rdata[VIS_BIT] && (idx != 2'd3)) begin
            idx   <= idx + 1'b1;
            state <= S_PROBE;
          end else if (cell_rdata[VIS_BIT] || stack_full) begin
            // no fresh neighbor left, or no room to push: backtrack
            count <= cnt_dec;
            res   <= '{EV_BACK, COORD_W'(cur_x), COORD_W'(cur_y), DIR_UP,
                       DEPTH_W'(cnt_dec)};
            state <= S_FINISH;
          end else begin
            nbr_walls <= cell_rdata[3:0];
            state     <= S_CUR;
          end
        end
        S_CUR: begin
          state <= S_NWR;
        end
        S_NWR: begin
          count <= cnt_inc;
          res   <= '{EV_CARVED, COORD_W'(cur_x), COORD_W'(cur_y), cur_dir,
                     DEPTH_W'(cnt_inc)};
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hand off once the output register is free
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // stack never grows past the map
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(CELLS))
    else $error("stack count beyond cell count");

  // a carve pushes exactly one cell
  a_carve_push: assert property (@(posedge clk) disable iff (rst)
    (state == S_NWR) |=> (count == $past(count) + 1'b1))
    else $error("carve did not push one cell");

  // a good restart leaves only the start cell on the stack
  a_seed_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEED && !cfg_bad) |=> (count == CNTW'(1)))
    else $error("restart depth not one");

  // a pending result moves out as soon as the output register frees up
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("result not handed off");

endmodule

// File: hw/rtl/mcdfs_ram.sv
// generic single-write, single-read ram with registered read data
module mcdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mcdfs_nbr.sv
// neighbor unit: bounds test and coordinates of the neighbor in one direction
module mcdfs_nbr
  import mcdfs_pkg::*;
#(
  parameter int XW  = 6,
  parameter int YW  = 6,
  parameter int XCW = 7,
  parameter int YCW = 7
) (
  input  logic [XW-1:0]  cur_x,
  input  logic [YW-1:0]  cur_y,
  input  logic [1:0]     dir,
  input  logic [XCW-1:0] used_w,
  input  logic [YCW-1:0] used_h,
  output logic           ok,
  output logic [XW-1:0]  nbr_x,
  output logic [YW-1:0]  nbr_y
);

  always_comb begin
    nbr_x = cur_x;
    nbr_y = cur_y;
    ok    = 1'b0;
    unique case (dir)
      DIR_UP: begin
        ok    = (cur_y != '0);
        nbr_y = cur_y - 1'b1;
      end
      DIR_RIGHT: begin
        ok    = ((XCW'(cur_x) + XCW'(1)) < used_w);
        nbr_x = cur_x + 1'b1;
      end
      DIR_DOWN: begin
        ok    = ((YCW'(cur_y) + YCW'(1)) < used_h);
        nbr_y = cur_y + 1'b1;
      end
      DIR_LEFT: begin
        ok    = (cur_x != '0);
        nbr_x = cur_x - 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule
